>>> rtl/core/trs_pkg.sv
// Package for the timed retry slot table.
// Holds the beat types, status and command codes and the sequencer states.
// No dependencies.
package trs_pkg;

  // Default number of retry slots.
  localparam int unsigned SLOTS_DEF = 8;

  // Command codes.
  localparam logic CMD_FETCH  = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_TAKEN      = 3'd0;
  localparam logic [2:0] ST_FULL_WAIT  = 3'd1;
  localparam logic [2:0] ST_ROOM_WAIT  = 3'd2;
  localparam logic [2:0] ST_STORED     = 3'd3;
  localparam logic [2:0] ST_REFUSED    = 3'd4;

  localparam logic [63:0] TIME_MAX = '1;

  // One request beat.
  typedef struct packed {
    logic        command;
    logic [63:0] now;
    logic [31:0] handle;
    logic [31:0] penalty;
  } req_t;

  // One response beat.
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] taken_handle;
    logic [63:0] earliest_ready;
    logic [3:0]  free_slots;
  } rsp_t;

  // One slot entry as kept in the slot memory.
  typedef struct packed {
    logic [31:0] handle;
    logic [63:0] due_time;
  } slot_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_INSERT,
    SEQ_SCAN,
    SEQ_FINISH
  } seq_state_t;

endpackage

>>> rtl/core/trs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the slot memory of the timed retry slot table; no dependencies.
module trs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/timed_retry_slot_table.sv
// Top level of the timed retry slot table: sequencer, valid bits and output register.
// Depends on trs_pkg and trs_ram (slot handles and ready times).
//
//   Channel | Direction | Handshake            | Beat
//   req     | in        | req_valid, req_stall | trs_pkg::req_t
//   rsp     | out       | rsp_valid, rsp_stall | trs_pkg::rsp_t
//
// From acceptance to a loaded response register: an insert goes through SEQ_INSERT, a
// fetch on an empty table to SEQ_FINISH, and any other fetch stays in SEQ_SCAN until a
// slot is taken or the last slot is checked; the single read port gives one slot per cycle.
// The next request is taken in the cycle after the response is loaded; one is in work.
// Reset clears the valid bits and sets the free count to SLOTS; no memory sweep.
// A new request is taken while an earlier response still waits under rsp_stall.
module timed_retry_slot_table #(
  parameter int unsigned SLOTS = trs_pkg::SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  trs_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output trs_pkg::rsp_t rsp
);

  import trs_pkg::*;

  localparam int unsigned IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW   = $clog2(SLOTS + 1);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);
  localparam logic [CW-1:0]   FULL_CNT = CW'(SLOTS);
  localparam int unsigned SW = $bits(slot_t);

  seq_state_t state, state_next;

  req_t            item;
  logic [SLOTS-1:0] valid_bits;
  logic [CW-1:0]   empty_count;
  logic [IDXW-1:0] issue_idx;
  logic            issue_done;
  logic            eval_pending;
  logic [IDXW-1:0] eval_idx;
  logic [63:0]     min_ready;
  rsp_t            res;

  logic            req_take;
  logic            load_rsp;
  logic            rd_en;
  logic            wr_en;
  logic [IDXW-1:0] free_idx;
  logic [IDXW-1:0] wr_addr;
  slot_t           wr_slot;
  slot_t           rd_slot;
  logic [SW-1:0]   rd_raw;
  logic [64:0]     ready_sum;
  logic [63:0]     ready_sat;
  logic            hit;
  logic            table_full;
  logic [63:0]     min_with_cur;

  // Slot memory holding handle and ready time per slot.
  trs_ram #(
    .WIDTH(SW),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(SW'(wr_slot)),
    .rd_en  (rd_en),
    .rd_addr(issue_idx),
    .rd_data(rd_raw)
  );

  assign rd_slot = slot_t'(rd_raw);

  // Lowest free slot, from the valid bits.
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_bits[i]) begin
        free_idx = IDXW'(i);
      end
    end
  end

  // Saturating ready time for an insert.
  assign ready_sum = {1'b0, item.now} + {33'd0, item.penalty};
  assign ready_sat = ready_sum[64] ? TIME_MAX : ready_sum[63:0];

  assign wr_addr = free_idx;
  assign wr_slot = '{handle: item.handle, due_time: ready_sat};

  // Evaluation of the slot whose read data has just arrived.
  assign table_full   = (empty_count == '0);
  assign hit          = eval_pending && valid_bits[eval_idx] && (item.now > rd_slot.due_time);
  assign min_with_cur = (rd_slot.due_time < min_ready) ? rd_slot.due_time : min_ready;

  assign req_take = req_valid && !req_stall;
  assign load_rsp = (state == SEQ_FINISH) && (!rsp_valid || !rsp_stall);

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      SEQ_IDLE: begin
        if (req_take) begin
          if (req.command == CMD_INSERT) begin
            state_next = SEQ_INSERT;
          end else if (empty_count == FULL_CNT) begin
            state_next = SEQ_FINISH;
          end else begin
            state_next = SEQ_SCAN;
          end
        end
      end
      SEQ_INSERT: state_next = SEQ_FINISH;
      SEQ_SCAN: begin
        if (hit || (eval_pending && eval_idx == LAST_IDX)) begin
          state_next = SEQ_FINISH;
        end
      end
      SEQ_FINISH: begin
        if (load_rsp) begin
          state_next = SEQ_IDLE;
        end
      end
      default: state_next = SEQ_IDLE;
    endcase
  end

  // Handshake and memory controls.
  always_comb begin
    req_stall = 1'b1;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    case (state)
      SEQ_IDLE:   req_stall = 1'b0;
      SEQ_INSERT: wr_en = !table_full;
      SEQ_SCAN:   rd_en = !issue_done;
      SEQ_FINISH: req_stall = 1'b1;
      default:    req_stall = 1'b1;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= SEQ_IDLE;
      valid_bits   <= '0;
      empty_count  <= FULL_CNT;
      eval_pending <= 1'b0;
      issue_done   <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      state <= state_next;
      // Response register: filled from the finished result, emptied by a taken beat.
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        SEQ_IDLE: begin
          issue_done   <= 1'b0;
          eval_pending <= 1'b0;
        end
        SEQ_INSERT: begin
          if (!table_full) begin
            valid_bits[free_idx] <= 1'b1;
            empty_count          <= empty_count - 1'b1;
          end
        end
        SEQ_SCAN: begin
          eval_pending <= rd_en;
          if (rd_en && issue_idx == LAST_IDX) begin
            issue_done <= 1'b1;
          end
          if (hit) begin
            valid_bits[eval_idx] <= 1'b0;
            empty_count          <= empty_count + 1'b1;
          end
        end
        SEQ_FINISH: eval_pending <= 1'b0;
        default: eval_pending <= 1'b0;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp <= res;
    end
    case (state)
      SEQ_IDLE: begin
        issue_idx <= '0;
        min_ready <= TIME_MAX;
        if (req_take) begin
          item <= req;
          // Fetch on an empty table answers at once.
          res  <= '{status: ST_ROOM_WAIT, taken_handle: '0,
                    earliest_ready: TIME_MAX, free_slots: 4'(empty_count)};
        end
      end
      SEQ_INSERT: begin
        if (table_full) begin
          res <= '{status: ST_REFUSED, taken_handle: '0,
                   earliest_ready: TIME_MAX, free_slots: 4'(empty_count)};
        end else begin
          res <= '{status: ST_STORED, taken_handle: '0,
                   earliest_ready: TIME_MAX, free_slots: 4'(empty_count - 1'b1)};
        end
      end
      SEQ_SCAN: begin
        if (rd_en) begin
          issue_idx <= issue_idx + 1'b1;
        end
        eval_idx <= issue_idx;
        if (eval_pending && table_full) begin
          min_ready <= min_with_cur;
        end
        if (hit) begin
          res <= '{status: ST_TAKEN, taken_handle: rd_slot.handle,
                   earliest_ready: TIME_MAX, free_slots: 4'(empty_count + 1'b1)};
        end else if (eval_pending && eval_idx == LAST_IDX) begin
          if (table_full) begin
            res <= '{status: ST_FULL_WAIT, taken_handle: '0,
                     earliest_ready: min_with_cur, free_slots: 4'(empty_count)};
          end else begin
            res <= '{status: ST_ROOM_WAIT, taken_handle: '0,
                     earliest_ready: TIME_MAX, free_slots: 4'(empty_count)};
          end
        end
      end
      SEQ_FINISH: issue_idx <= '0;
      default: issue_idx <= '0;
    endcase
  end

endmodule
